// ===== design/sha1_pkg.sv =====
`default_nettype none

package sha1_pkg;

	localparam int unsigned DIGEST_WORDS = 5;
	localparam int unsigned ROUNDS       = 80;

	localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
		32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
	};

	localparam logic [31:0] K_0 = 32'h5A82_7999;
	localparam logic [31:0] K_1 = 32'h6ED9_EBA1;
	localparam logic [31:0] K_2 = 32'h8F1B_BCDC;
	localparam logic [31:0] K_3 = 32'hCA62_C1D6;

	localparam logic [7:0]  PAD_MARK   = 8'h80;
	localparam logic [31:0] PAD_WORD   = {PAD_MARK, 24'h0};
	localparam logic [6:0]  LAST_ROUND = 7'(ROUNDS - 1);
	localparam logic [6:0]  ISSUE_DONE = 7'(ROUNDS);
	localparam logic [2:0]  LAST_IDX   = 3'(DIGEST_WORDS - 1);
	localparam logic [3:0]  LEN_HI_POS = 4'd14;
	localparam logic [3:0]  BLOCK_END  = 4'd15;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} sha1_vars_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} sha1_state_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned k);
		rotl = (v << k) | (v >> (32 - k));
	endfunction

endpackage

`default_nettype wire

// ===== design/sha1_in_if.sv =====
`default_nettype none

interface sha1_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        is_last;

	modport source (output valid, output data_word, output byte_count, output is_last,
		input ready);
	modport sink (input valid, input data_word, input byte_count, input is_last,
		output ready);
endinterface

`default_nettype wire

// ===== design/sha1_out_if.sv =====
`default_nettype none

interface sha1_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

`default_nettype wire

// ===== design/sha1_round.sv =====
`default_nettype none

// One SHA-1 round: selects f and K by round number and updates a..e.
module sha1_round (
	input  var sha1_pkg::sha1_vars_t cur,
	input  wire logic [31:0]         w,
	input  wire logic [6:0]          t,
	output sha1_pkg::sha1_vars_t     nxt
);
	import sha1_pkg::*;

	logic [31:0] f;
	logic [31:0] k;

	always_comb begin
		if (t < 7'd20) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = K_0;
		end else if (t < 7'd40) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_1;
		end else if (t < 7'd60) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = K_2;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_3;
		end
	end

	always_comb begin
		nxt.a = rotl(cur.a, 5) + f + cur.e + w + k;
		nxt.b = cur.a;
		nxt.c = rotl(cur.b, 30);
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

`default_nettype wire

// ===== design/sha1_stream_hash.sv =====
// After the last item of a message, the block writes the padding words, compresses the
// one or two blocks still open and adds each result into the chaining value before the
// first digest item. A 16-item block is accepted and then compressed in 80 rounds, one
// per cycle from the schedule memory; no new item is taken until that block is done.
// Reset: arst_n clears the control state and loads the initial chaining value; the
// schedule memory is not cleared, since every entry is written before it is read.
`default_nettype none

module sha1_stream_hash (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sha1_in_if.sink    msg,
	sha1_out_if.source digest
);
	import sha1_pkg::*;

	// Control state.
	sha1_state_t state_q;
	sha1_state_t state_d;

	// The 16-word message schedule lives in a memory with two registered read ports.
	// Round t reads W[t-14] on port A and W[t-8] on port B (or W[t] in the first 16
	// rounds). W[t-16] is port A data delayed two rounds and W[t-3] comes from a short
	// line of the words used by the last three rounds, so nothing reads an entry that
	// is being written in the same cycle.
	logic [31:0] sched_mem [16];
	logic [31:0] rd_a_s1;
	logic [31:0] rd_b_s1;
	logic [3:0]  addr_a;
	logic [3:0]  addr_b;
	logic        mem_we;
	logic [3:0]  mem_waddr;
	logic [31:0] mem_wdata;

	logic [31:0] chain_q [DIGEST_WORDS];
	sha1_vars_t  vars_q;
	sha1_vars_t  vars_nxt;
	logic [63:0] bit_len_q;
	logic [3:0]  fill_q;
	logic [6:0]  iss_q;
	logic        ex_v_s1;
	logic [6:0]  ex_t_s1;
	logic [31:0] pa_q1;
	logic [31:0] pa_q2;
	logic [31:0] wm1_q;
	logic [31:0] wm2_q;
	logic [31:0] wm3_q;
	logic [31:0] w_cur;
	logic [2:0]  idx_q;

	// Padding progress: pad_q while a message is being closed, pad_80_q when the
	// marker word still has to go in, len_lo_q when the low length word is next,
	// fin_q while the final block of the message is compressed.
	logic pad_q;
	logic pad_80_q;
	logic len_lo_q;
	logic fin_q;

	logic        in_fire;
	logic        out_fire;
	logic        push_v;
	logic [31:0] push_word;
	logic        block_full;
	logic        issue_v;
	logic        ex_last;
	logic [2:0]  cnt_eff;
	logic [31:0] last_word_val;

	assign in_fire    = msg.valid && msg.ready;
	assign out_fire   = digest.valid && digest.ready;
	assign block_full = push_v && (fill_q == BLOCK_END);
	assign ex_last    = ex_v_s1 && (ex_t_s1 == LAST_ROUND);

	// A count above four, or any count on an item that is not last, means a full word.
	assign cnt_eff = (!msg.is_last || msg.byte_count > 3'd4) ? 3'd4 : msg.byte_count;

	// The last item keeps its valid bytes and gets the marker byte right after them.
	always_comb begin
		case (cnt_eff)
			3'd0:    last_word_val = PAD_WORD;
			3'd1:    last_word_val = {msg.data_word[31:24], PAD_MARK, 16'h0};
			3'd2:    last_word_val = {msg.data_word[31:16], PAD_MARK, 8'h0};
			3'd3:    last_word_val = {msg.data_word[31:8], PAD_MARK};
			default: last_word_val = msg.data_word;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (block_full) begin
						state_d = ST_ROUND;
					end else if (msg.is_last) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (block_full) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (ex_last) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (fin_q) begin
					state_d = ST_OUT;
				end else if (pad_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_fire && idx_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		msg.ready    = 1'b0;
		digest.valid = 1'b0;
		push_v       = 1'b0;
		push_word    = '0;
		issue_v      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				msg.ready = 1'b1;
				push_v    = in_fire;
				push_word = last_word_val;
			end
			ST_PAD: begin
				push_v = 1'b1;
				if (pad_80_q) begin
					push_word = PAD_WORD;
				end else if (len_lo_q) begin
					push_word = bit_len_q[31:0];
				end else if (fill_q == LEN_HI_POS) begin
					push_word = bit_len_q[63:32];
				end else begin
					push_word = '0;
				end
			end
			ST_ROUND: begin
				issue_v = (iss_q != ISSUE_DONE);
			end
			ST_ADD: begin
			end
			ST_OUT: begin
				digest.valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign digest.digest_word = chain_q[idx_q];
	assign digest.word_index  = idx_q;
	assign digest.last_word   = (idx_q == LAST_IDX);

	// Read addresses for the round being issued.
	assign addr_a = iss_q[3:0] + 4'd2;
	assign addr_b = (iss_q < 7'd16) ? iss_q[3:0] : iss_q[3:0] + 4'd8;

	// Schedule word used by the round in execution.
	always_comb begin
		if (ex_t_s1 < 7'd16) begin
			w_cur = rd_b_s1;
		end else begin
			w_cur = rotl(wm3_q ^ rd_b_s1 ^ rd_a_s1 ^ pa_q2, 1);
		end
	end

	assign mem_we    = push_v || (ex_v_s1 && ex_t_s1 >= 7'd16);
	assign mem_waddr = push_v ? fill_q : ex_t_s1[3:0];
	assign mem_wdata = push_v ? push_word : w_cur;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sched_mem[mem_waddr] <= mem_wdata;
		end
		rd_a_s1 <= sched_mem[addr_a];
		rd_b_s1 <= sched_mem[addr_b];
	end

	sha1_round u_round (
		.cur (vars_q),
		.w   (w_cur),
		.t   (ex_t_s1),
		.nxt (vars_nxt)
	);

	// Schedule delay lines; they only move while a round executes.
	always_ff @(posedge clk) begin
		if (ex_v_s1) begin
			pa_q1 <= rd_a_s1;
			pa_q2 <= pa_q1;
			wm1_q <= w_cur;
			wm2_q <= wm1_q;
			wm3_q <= wm2_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			vars_q    <= '0;
			bit_len_q <= '0;
			fill_q    <= '0;
			iss_q     <= '0;
			ex_v_s1   <= 1'b0;
			ex_t_s1   <= '0;
			idx_q     <= '0;
			pad_q     <= 1'b0;
			pad_80_q  <= 1'b0;
			len_lo_q  <= 1'b0;
			fin_q     <= 1'b0;
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				chain_q[i] <= H_INIT[i];
			end
		end else begin
			state_q <= state_d;

			if (push_v) begin
				fill_q <= fill_q + 4'd1;
			end

			// Start of a compression: working variables take the chaining value.
			if (block_full) begin
				vars_q <= '{a: chain_q[0], b: chain_q[1], c: chain_q[2],
					d: chain_q[3], e: chain_q[4]};
				iss_q  <= '0;
			end else if (ex_v_s1) begin
				vars_q <= vars_nxt;
			end
			if (issue_v) begin
				iss_q <= iss_q + 7'd1;
			end
			ex_v_s1 <= issue_v;
			ex_t_s1 <= iss_q;

			if (in_fire) begin
				bit_len_q <= bit_len_q + {58'd0, cnt_eff, 3'b000};
				if (msg.is_last) begin
					pad_q    <= 1'b1;
					pad_80_q <= (cnt_eff == 3'd4);
				end
			end

			if (state_q == ST_PAD) begin
				if (pad_80_q) begin
					pad_80_q <= 1'b0;
				end else if (len_lo_q) begin
					len_lo_q <= 1'b0;
					pad_q    <= 1'b0;
					fin_q    <= 1'b1;
				end else if (fill_q == LEN_HI_POS) begin
					len_lo_q <= 1'b1;
				end
			end

			if (state_q == ST_ADD) begin
				chain_q[0] <= chain_q[0] + vars_q.a;
				chain_q[1] <= chain_q[1] + vars_q.b;
				chain_q[2] <= chain_q[2] + vars_q.c;
				chain_q[3] <= chain_q[3] + vars_q.d;
				chain_q[4] <= chain_q[4] + vars_q.e;
			end

			// After the fifth digest item the next message starts from scratch.
			if (out_fire) begin
				if (idx_q == LAST_IDX) begin
					idx_q     <= '0;
					fin_q     <= 1'b0;
					bit_len_q <= '0;
					for (int i = 0; i < DIGEST_WORDS; i++) begin
						chain_q[i] <= H_INIT[i];
					end
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sha1_pkg::*;

	// The run is stopped as failed if it ever gets this far. The slowest legal run is
	// far shorter: every item and every digest word waits only for a random gap, each
	// message costs at most three compressions, and the receiver holds off once for
	// HOLD_CYCLES.
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned HOLD_CYCLES  = 600;
	// The last digest word can trail the last accepted item by two compressions and
	// the padding words.
	localparam int unsigned DRAIN_CYCLES = 300;
	localparam int unsigned RANDOM_ITEMS = 120;

	// One digest word as it leaves the block.
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        closes;
	} digest_item_t;

	// Scoreboard: it follows the message stream on its own SHA-1 engine and keeps the
	// digest words that the block still owes, in order.
	class digest_scoreboard;
		logic [31:0]  chain [DIGEST_WORDS];
		logic [31:0]  block_words [16];
		int unsigned  fill;
		logic [63:0]  msg_bits;
		digest_item_t owed_digests [$];
		int unsigned  failures;

		function new();
			chain = H_INIT;
			fill = 0;
			msg_bits = '0;
			failures = 0;
		endfunction

		function int unsigned pending();
			return owed_digests.size();
		endfunction

		// Eighty rounds over the buffered block, with the whole schedule expanded first.
		function void compress_block();
			logic [31:0] sched [80];
			logic [31:0] a, b, c, d, e, f, k, t, x;
			for (int i = 0; i < 16; i++)
				sched[i] = block_words[i];
			for (int i = 16; i < 80; i++) begin
				x = sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16];
				sched[i] = {x[30:0], x[31]};
			end
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (int i = 0; i < 80; i++) begin
				if (i < 20) begin
					f = (b & c) | (~b & d);
					k = K_0;
				end else if (i < 40) begin
					f = b ^ c ^ d;
					k = K_1;
				end else if (i < 60) begin
					f = (b & c) | (b & d) | (c & d);
					k = K_2;
				end else begin
					f = b ^ c ^ d;
					k = K_3;
				end
				t = {a[26:0], a[31:27]} + f + e + sched[i] + k;
				e = d;
				d = c;
				c = {b[1:0], b[31:2]};
				b = a;
				a = t;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
			chain[4] += e;
		endfunction

		function void push_word(logic [31:0] w);
			block_words[fill] = w;
			fill++;
			if (fill == 16) begin
				compress_block();
				fill = 0;
			end
		endfunction

		// Called for every item the block accepts.
		function void absorb_item(logic [31:0] w, logic [2:0] count, logic last);
			int unsigned bytes;
			logic [31:0] keep;
			// Counts only matter on the last item, and anything above four means four.
			bytes = (!last || count > 3'd4) ? 4 : int'(count);
			msg_bits += 64'(bytes * 8);
			if (!last) begin
				push_word(w);
				return;
			end
			if (bytes == 4) begin
				push_word(w);
				push_word(PAD_WORD);
			end else begin
				keep = ~(32'hFFFF_FFFF >> (8 * bytes));
				push_word((w & keep) | (PAD_WORD >> (8 * bytes)));
			end
			while (fill != 14)
				push_word('0);
			push_word(msg_bits[63:32]);
			push_word(msg_bits[31:0]);
			for (int i = 0; i < DIGEST_WORDS; i++)
				owed_digests.push_back('{chain[i], 3'(i), i == DIGEST_WORDS - 1});
			chain = H_INIT;
			msg_bits = '0;
			fill = 0;
		endfunction

		// Called for every digest word the block hands over.
		function void check_digest(logic [31:0] word, logic [2:0] index, logic closes);
			digest_item_t owed;
			if (owed_digests.size() == 0) begin
				$error("digest word %h (index %0d) arrived with none outstanding",
					word, index);
				failures++;
				return;
			end
			owed = owed_digests.pop_front();
			if (word !== owed.word) begin
				$error("digest_word mismatch: expected %h, actual %h", owed.word, word);
				failures++;
			end
			if (index !== owed.index) begin
				$error("word_index mismatch: expected %0d, actual %0d", owed.index, index);
				failures++;
			end
			if (closes !== owed.closes) begin
				$error("last_word mismatch: expected %b, actual %b", owed.closes, closes);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int unsigned cycle_count;

	// Burst flags: while one is set, its side draws no random gaps. Each side flips its own
	// flag now and then so that runs without gaps alternate with ragged traffic.
	bit src_steady;
	bit snk_steady;
	// Set by the stimulus to make the receiver hold off for a long stretch.
	bit hold_digest;

	digest_scoreboard sb;

	sha1_in_if  msg_ch ();
	sha1_out_if dig_ch ();

	sha1_stream_hash DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (dig_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog over the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Offers one item and waits until the block takes it. Entered and left at a
	// falling edge; the payload changes only there. With no gap drawn, valid simply
	// stays high and the next payload replaces the old one.
	task automatic send_item(input logic [31:0] w, input logic [2:0] count, input logic last);
		int unsigned gap;
		if ($urandom_range(0, 15) == 0)
			src_steady = !src_steady;
		gap = src_steady ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			msg_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		msg_ch.valid      <= 1'b1;
		msg_ch.data_word  <= w;
		msg_ch.byte_count <= count;
		msg_ch.is_last    <= last;
		do
			@(posedge clk);
		while (msg_ch.ready !== 1'b1);
		sb.absorb_item(w, count, last);
		@(negedge clk);
	endtask

	// Directed messages: the empty message, short tails with junk in the unused
	// bytes, counts above four, a short count on a word that is not last, a full
	// last word, and a message whose padding spills into a second block.
	task automatic run_directed();
		send_item(32'h0000_0000, 3'd0, 1'b1);
		send_item(32'h6162_63A5, 3'd3, 1'b1);
		send_item(32'hFFFF_FFFF, 3'd7, 1'b1);
		send_item(32'h1234_5678, 3'd5, 1'b1);
		send_item(32'h9ABC_DEF0, 3'd6, 1'b1);
		send_item(32'hDEAD_BEEF, 3'd1, 1'b0);
		send_item(32'hFFFF_FFFF, 3'd2, 1'b1);
		send_item(32'hFFFF_FFFF, 3'd0, 1'b0);
		send_item(32'h0000_0000, 3'd4, 1'b1);
		// Thirteen full words plus a full last word leave no room for the length.
		for (int i = 0; i < 13; i++)
			send_item($urandom, 3'($urandom_range(0, 7)), 1'b0);
		send_item(32'hA5A5_5A5A, 3'd4, 1'b1);
	endtask

	// Random messages, mostly short, some spanning one or two blocks and a few
	// longer ones. Counts on inner words are random, since the block must ignore them.
	task automatic run_random();
		int unsigned sent;
		int unsigned len;
		int unsigned pick;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				len = $urandom_range(1, 8);
			else if (pick < 9)
				len = $urandom_range(9, 20);
			else
				len = $urandom_range(21, 40);
			for (int i = 1; i < len; i++)
				send_item($urandom, 3'($urandom_range(0, 7)), 1'b0);
			send_item($urandom, 3'($urandom_range(0, 7)), 1'b1);
			sent += len;
		end
	endtask

	// Stimulus and end of run.
	initial begin
		sb = new();
		cycle_count = 0;
		src_steady = 1'b0;
		snk_steady = 1'b0;
		hold_digest = 1'b0;
		arst_n = 1'b0;
		msg_ch.valid = 1'b0;
		msg_ch.data_word = '0;
		msg_ch.byte_count = '0;
		msg_ch.is_last = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		// The receiver will now sit on its next digest word for a long time while
		// messages keep coming, so the block has to back up and refuse input.
		hold_digest = 1'b1;
		run_random();
		msg_ch.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		// Anything arriving after this point is a digest word nobody asked for.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Digest receiver with random stalls. Like the sender, it moves ready only at a
	// falling edge and looks at the channel at the rising edge.
	initial begin
		int unsigned gap;
		dig_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_digest) begin
				hold_digest = 1'b0;
				dig_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if ($urandom_range(0, 15) == 0)
				snk_steady = !snk_steady;
			gap = snk_steady ? 0 : $urandom_range(0, 8);
			if (gap != 0) begin
				dig_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			dig_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (dig_ch.valid !== 1'b1);
			sb.check_digest(dig_ch.digest_word, dig_ch.word_index, dig_ch.last_word);
			@(negedge clk);
		end
	end

endmodule

`default_nettype wire

// ===== sha1_stream_hash.f =====
design/sha1_pkg.sv
design/sha1_in_if.sv
design/sha1_out_if.sv
design/sha1_round.sv
design/sha1_stream_hash.sv
tb/sv/testbench.sv
